FILE: rtl/htt_pkg.sv
`default_nettype none
package htt_pkg;

    // event codes
    localparam logic [3:0] EV_CHAR    = 4'd0;
    localparam logic [3:0] EV_EOF     = 4'd1;
    localparam logic [3:0] EV_START   = 4'd2;
    localparam logic [3:0] EV_END     = 4'd3;
    localparam logic [3:0] EV_NAME    = 4'd4;
    localparam logic [3:0] EV_ABEGIN  = 4'd5;
    localparam logic [3:0] EV_ANAME   = 4'd6;
    localparam logic [3:0] EV_AVAL    = 4'd7;
    localparam logic [3:0] EV_DOCTYPE = 4'd8;
    localparam logic [3:0] EV_DCHAR   = 4'd9;
    localparam logic [3:0] EV_DONE    = 4'd10;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] char_value;
        logic       has_char;
        logic       slash_end;
    } res_t;

    typedef struct packed {
        logic [3:0] parse_state;
        logic [2:0] keyword_progress;
        logic       closing_flag;
    } state_t;

    typedef struct packed {
        logic emit;
        res_t res;
    } step_t;

endpackage
`default_nettype wire

FILE: rtl/htt_if.sv
`default_nettype none
interface htt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface htt_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] char_value;
    logic       has_char;
    logic       slash_end;

    modport source (output valid, output event_res, output char_value, output has_char,
                    output slash_end, input ready);
    modport sink (input valid, input event_res, input char_value, input has_char,
                  input slash_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/htt_step.sv
`default_nettype none
module htt_step
    import htt_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire state_t     cur,
    output state_t          nxt,
    output step_t           step
);

    localparam logic [3:0] ST_DATA         = 4'd0;
    localparam logic [3:0] ST_TAG_OPEN     = 4'd1;
    localparam logic [3:0] ST_TAG_NAME     = 4'd2;
    localparam logic [3:0] ST_SELF_CLOSE   = 4'd3;
    localparam logic [3:0] ST_BEFORE_ANAME = 4'd4;
    localparam logic [3:0] ST_ANAME        = 4'd5;
    localparam logic [3:0] ST_AFTER_ANAME  = 4'd6;
    localparam logic [3:0] ST_BEFORE_AVAL  = 4'd7;
    localparam logic [3:0] ST_AVAL_SQ      = 4'd8;
    localparam logic [3:0] ST_AVAL_DQ      = 4'd9;
    localparam logic [3:0] ST_AFTER_AVAL   = 4'd10;
    localparam logic [3:0] ST_END_OPEN     = 4'd11;
    localparam logic [3:0] ST_MARKUP       = 4'd12;
    localparam logic [3:0] ST_DOCTYPE      = 4'd13;
    localparam logic [3:0] ST_BEFORE_DNAME = 4'd14;
    localparam logic [3:0] ST_DNAME        = 4'd15;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] KW_LEN   = 3'd7;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_TAB, CH_LF, CH_FF, CH_SP};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    // letters of "DOCTYPE"
    function automatic logic [7:0] kw_char(input logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd0:    ch = 8'h44;
            3'd1:    ch = 8'h4F;
            3'd2:    ch = 8'h43;
            3'd3:    ch = 8'h54;
            3'd4:    ch = 8'h59;
            3'd5:    ch = 8'h50;
            3'd6:    ch = 8'h45;
            default: ch = 8'h44;
        endcase
        return ch;
    endfunction

    function automatic res_t mk_res(input logic [3:0] ev, input logic [7:0] c,
                                    input logic has, input logic sc);
        res_t r;
        r.event_res  = ev;
        r.char_value = has ? c : 8'h00;
        r.has_char   = has;
        r.slash_end  = sc;
        return r;
    endfunction

    logic [7:0] c;
    // before-attribute-name handling, shared with the self-closing fall-through
    logic [3:0] ban_state;
    logic       ban_closing;
    logic       ban_emit;
    res_t       ban_res;
    logic [2:0] kw_p;
    logic [2:0] kw_p1;

    assign c = byte_in;

    always_comb
    begin
        ban_state   = ST_BEFORE_ANAME;
        ban_closing = 1'b0;
        ban_emit    = 1'b0;
        ban_res     = mk_res(EV_ABEGIN, c, 1'b1, 1'b0);
        if (is_space(c))
        begin
            ban_state = ST_BEFORE_ANAME;
        end
        else if (c == CH_GT)
        begin
            ban_state = ST_DATA;
            ban_emit  = 1'b1;
            ban_res   = mk_res(EV_DONE, c, 1'b0, 1'b0);
        end
        else if (c == CH_SLASH)
        begin
            ban_state   = ST_SELF_CLOSE;
            ban_closing = 1'b1;
        end
        else if (c == CH_EQ)
        begin
            ban_state = ST_BEFORE_AVAL;
            ban_emit  = 1'b1;
            ban_res   = mk_res(EV_ABEGIN, c, 1'b0, 1'b0);
        end
        else
        begin
            ban_state = ST_ANAME;
            ban_emit  = 1'b1;
        end
    end

    assign kw_p  = (cur.keyword_progress >= KW_LEN) ? 3'd0 : cur.keyword_progress;
    assign kw_p1 = kw_p + 3'd1;

    always_comb
    begin
        nxt       = cur;
        step.emit = 1'b0;
        step.res  = mk_res(EV_CHAR, c, 1'b0, 1'b0);
        case (cur.parse_state)
            ST_DATA:
            begin
                if (c == CH_LT)
                begin
                    nxt.parse_state = ST_TAG_OPEN;
                end
                else if (!is_space(c))
                begin
                    step.emit = 1'b1;
                    step.res  = (c == CH_NUL) ? mk_res(EV_EOF, c, 1'b0, 1'b0)
                                              : mk_res(EV_CHAR, c, 1'b1, 1'b0);
                end
            end
            ST_TAG_OPEN:
            begin
                if (c == CH_BANG)
                begin
                    nxt.parse_state      = ST_MARKUP;
                    nxt.keyword_progress = 3'd0;
                end
                else if (c == CH_SLASH)
                begin
                    nxt.parse_state = ST_END_OPEN;
                end
                else if (is_alpha(c))
                begin
                    nxt.parse_state = ST_TAG_NAME;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_START, c, 1'b1, 1'b0);
                end
            end
            ST_TAG_NAME:
            begin
                if (c == CH_GT)
                begin
                    nxt.parse_state = ST_DATA;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_DONE, c, 1'b0, 1'b0);
                end
                else if (c == CH_SLASH)
                begin
                    nxt.parse_state  = ST_SELF_CLOSE;
                    nxt.closing_flag = 1'b1;
                end
                else if (is_space(c))
                begin
                    nxt.parse_state = ST_BEFORE_ANAME;
                end
                else
                begin
                    step.emit = 1'b1;
                    step.res  = mk_res(EV_NAME, c, 1'b1, 1'b0);
                end
            end
            ST_SELF_CLOSE:
            begin
                if (c == CH_GT)
                begin
                    nxt.parse_state  = ST_DATA;
                    nxt.closing_flag = 1'b0;
                    step.emit        = 1'b1;
                    step.res         = mk_res(EV_DONE, c, 1'b0, cur.closing_flag);
                end
                else
                begin
                    // slash not closing the tag: reprocess as before attribute name
                    nxt.parse_state  = ban_state;
                    nxt.closing_flag = ban_closing;
                    step.emit        = ban_emit;
                    step.res         = ban_res;
                end
            end
            ST_BEFORE_ANAME:
            begin
                nxt.parse_state = ban_state;
                if (ban_closing)
                begin
                    nxt.closing_flag = 1'b1;
                end
                step.emit = ban_emit;
                step.res  = ban_res;
            end
            ST_ANAME:
            begin
                if (is_space(c))
                begin
                    nxt.parse_state = ST_AFTER_ANAME;
                end
                else if (c == CH_GT)
                begin
                    nxt.parse_state = ST_DATA;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_DONE, c, 1'b0, 1'b0);
                end
                else if (c == CH_EQ)
                begin
                    nxt.parse_state = ST_BEFORE_AVAL;
                end
                else
                begin
                    step.emit = 1'b1;
                    step.res  = mk_res(EV_ANAME, c, 1'b1, 1'b0);
                end
            end
            ST_AFTER_ANAME, ST_AFTER_AVAL:
            begin
                if (c == CH_GT)
                begin
                    nxt.parse_state = ST_DATA;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_DONE, c, 1'b0, 1'b0);
                end
                else if (c == CH_SLASH)
                begin
                    nxt.parse_state  = ST_SELF_CLOSE;
                    nxt.closing_flag = 1'b1;
                end
                else if (is_space(c) && cur.parse_state == ST_AFTER_AVAL)
                begin
                    nxt.parse_state = ST_BEFORE_ANAME;
                end
            end
            ST_BEFORE_AVAL:
            begin
                if (c == CH_SQ)
                begin
                    nxt.parse_state = ST_AVAL_SQ;
                end
                else if (c == CH_DQ)
                begin
                    nxt.parse_state = ST_AVAL_DQ;
                end
            end
            ST_AVAL_SQ, ST_AVAL_DQ:
            begin
                if ((cur.parse_state == ST_AVAL_SQ && c == CH_SQ) ||
                    (cur.parse_state == ST_AVAL_DQ && c == CH_DQ))
                begin
                    nxt.parse_state = ST_AFTER_AVAL;
                end
                else
                begin
                    step.emit = 1'b1;
                    step.res  = mk_res(EV_AVAL, c, 1'b1, 1'b0);
                end
            end
            ST_END_OPEN:
            begin
                if (is_alpha(c))
                begin
                    nxt.parse_state = ST_TAG_NAME;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_END, c, 1'b1, 1'b0);
                end
            end
            ST_MARKUP:
            begin
                if (c == kw_char(kw_p))
                begin
                    if (kw_p1 == KW_LEN)
                    begin
                        nxt.keyword_progress = 3'd0;
                        nxt.parse_state      = ST_DOCTYPE;
                    end
                    else
                    begin
                        nxt.keyword_progress = kw_p1;
                    end
                end
                else
                begin
                    nxt.keyword_progress = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
                end
            end
            ST_DOCTYPE:
            begin
                if (is_space(c))
                begin
                    nxt.parse_state = ST_BEFORE_DNAME;
                end
            end
            ST_BEFORE_DNAME:
            begin
                nxt.parse_state = ST_DNAME;
                step.emit       = 1'b1;
                step.res        = mk_res(EV_DOCTYPE, c, 1'b1, 1'b0);
            end
            default:
            begin
                // doctype name
                if (c == CH_GT)
                begin
                    nxt.parse_state = ST_DATA;
                    step.emit       = 1'b1;
                    step.res        = mk_res(EV_DONE, c, 1'b0, 1'b0);
                end
                else
                begin
                    step.emit = 1'b1;
                    step.res  = mk_res(EV_DCHAR, c, 1'b1, 1'b0);
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/htt_res_reg.sv
`default_nettype none
module htt_res_reg
    import htt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire res_t       res_in,
    output logic            can_load,
    htt_event_if.source     out_ch
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load   = !valid_reg || out_ch.ready;
    assign valid_next = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.event_res  = res_reg.event_res;
    assign out_ch.char_value = res_reg.char_value;
    assign out_ch.has_char   = res_reg.has_char;
    assign out_ch.slash_end  = res_reg.slash_end;

endmodule
`default_nettype wire

FILE: rtl/html_tag_tokenizer.sv
// A byte is held in the input register while its event is decoded; its event word is then
// registered in the result register and offered on the output from there.
// Throughput: one byte per cycle; the input register and the result register both advance
// in the same cycle, and bytes that give no event pass without touching the result register.
// Only a full result register that is not being taken holds a byte that gives an event.
// Reset (rst_n, async, active low): both stages empty, tokenizer in data state,
// keyword counter and self-closing flag cleared.
`default_nettype none
module html_tag_tokenizer
    import htt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    htt_byte_if.sink    in_ch,
    htt_event_if.source out_ch
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    step_t      step;
    logic       can_load;
    logic       s1_fire;
    logic       in_accept;

    assign s1_fire       = s1_valid_reg && (!step.emit || can_load);
    assign in_ch.ready   = !s1_valid_reg || s1_fire;
    assign in_accept     = in_ch.valid && in_ch.ready;
    assign s1_valid_next = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= in_ch.byte_in;
        end
    end

    htt_step u_step (
        .byte_in (s1_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .step    (step)
    );

    htt_res_reg u_res (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_fire && step.emit),
        .res_in   (step.res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule
`default_nettype wire

FILE: tb/html_tag_tokenizer_test.sv
`timescale 1ns / 1ps

module html_tag_tokenizer_test;
    import htt_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_D     = 8'h44;

    localparam logic [55:0] DOCTYPE_KW  = "DOCTYPE";
    localparam int          DOCTYPE_LEN = 7;

    typedef enum logic [3:0] {
        PS_DATA, PS_TAG_OPEN, PS_TAG_NAME, PS_SELF_CLOSE,
        PS_BEFORE_ANAME, PS_ANAME, PS_AFTER_ANAME, PS_BEFORE_AVAL,
        PS_AVAL_SQ, PS_AVAL_DQ, PS_AFTER_AVAL, PS_END_OPEN,
        PS_MARKUP, PS_DOCTYPE, PS_BEFORE_DNAME, PS_DNAME
    } tok_state_e;

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_SP;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Tokenizer state mirror plus the queue of event words still owed by the block
    class token_scoreboard;
        tok_state_e st;
        logic [2:0] kw_pos;
        logic       slash_seen;
        res_t       words_q[$];
        int         errors;
        int         matched;
        int         seen;
        int         ev_count[16];

        function new();
            st         = PS_DATA;
            kw_pos     = '0;
            slash_seen = 1'b0;
            errors     = 0;
            matched    = 0;
            seen       = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
        endfunction

        function int pending();
            return words_q.size();
        endfunction

        function void queue_word(logic [3:0] ev, logic [7:0] c, logic has, logic sc);
            res_t w;
            w.event_res  = ev;
            w.char_value = has ? c : 8'h00;
            w.has_char   = has;
            w.slash_end  = sc;
            words_q.push_back(w);
        endfunction

        function void before_attr(logic [7:0] c);
            if (is_ws(c))
                return;
            if (c == CH_GT) begin
                st = PS_DATA;
                queue_word(EV_DONE, 8'h00, 1'b0, 1'b0);
            end else if (c == CH_SLASH) begin
                st         = PS_SELF_CLOSE;
                slash_seen = 1'b1;
            end else if (c == CH_EQ) begin
                // empty attribute name
                st = PS_BEFORE_AVAL;
                queue_word(EV_ABEGIN, 8'h00, 1'b0, 1'b0);
            end else begin
                st = PS_ANAME;
                queue_word(EV_ABEGIN, c, 1'b1, 1'b0);
            end
        endfunction

        function void note_byte(logic [7:0] c);
            int p;
            seen++;
            case (st)
                PS_DATA:
                    if (c == CH_LT)
                        st = PS_TAG_OPEN;
                    else if (!is_ws(c)) begin
                        if (c == CH_NUL)
                            queue_word(EV_EOF, 8'h00, 1'b0, 1'b0);
                        else
                            queue_word(EV_CHAR, c, 1'b1, 1'b0);
                    end
                PS_TAG_OPEN:
                    if (c == CH_BANG) begin
                        st     = PS_MARKUP;
                        kw_pos = '0;
                    end else if (c == CH_SLASH)
                        st = PS_END_OPEN;
                    else if (is_letter(c)) begin
                        st = PS_TAG_NAME;
                        queue_word(EV_START, c, 1'b1, 1'b0);
                    end
                PS_TAG_NAME:
                    if (c == CH_GT) begin
                        st = PS_DATA;
                        queue_word(EV_DONE, 8'h00, 1'b0, 1'b0);
                    end else if (c == CH_SLASH) begin
                        st         = PS_SELF_CLOSE;
                        slash_seen = 1'b1;
                    end else if (is_ws(c))
                        st = PS_BEFORE_ANAME;
                    else
                        queue_word(EV_NAME, c, 1'b1, 1'b0);
                PS_SELF_CLOSE:
                    if (c == CH_GT) begin
                        queue_word(EV_DONE, 8'h00, 1'b0, slash_seen);
                        slash_seen = 1'b0;
                        st         = PS_DATA;
                    end else begin
                        // lone slash: byte goes round again as an attribute start
                        slash_seen = 1'b0;
                        st         = PS_BEFORE_ANAME;
                        before_attr(c);
                    end
                PS_BEFORE_ANAME:
                    before_attr(c);
                PS_ANAME:
                    if (is_ws(c))
                        st = PS_AFTER_ANAME;
                    else if (c == CH_GT) begin
                        st = PS_DATA;
                        queue_word(EV_DONE, 8'h00, 1'b0, 1'b0);
                    end else if (c == CH_EQ)
                        st = PS_BEFORE_AVAL;
                    else
                        queue_word(EV_ANAME, c, 1'b1, 1'b0);
                PS_AFTER_ANAME, PS_AFTER_AVAL:
                    if (st == PS_AFTER_AVAL && is_ws(c))
                        st = PS_BEFORE_ANAME;
                    else if (c == CH_GT) begin
                        st = PS_DATA;
                        queue_word(EV_DONE, 8'h00, 1'b0, 1'b0);
                    end else if (c == CH_SLASH) begin
                        st         = PS_SELF_CLOSE;
                        slash_seen = 1'b1;
                    end
                PS_BEFORE_AVAL:
                    if (c == CH_SQ)
                        st = PS_AVAL_SQ;
                    else if (c == CH_DQ)
                        st = PS_AVAL_DQ;
                PS_AVAL_SQ, PS_AVAL_DQ:
                    if ((st == PS_AVAL_SQ && c == CH_SQ) || (st == PS_AVAL_DQ && c == CH_DQ))
                        st = PS_AFTER_AVAL;
                    else
                        queue_word(EV_AVAL, c, 1'b1, 1'b0);
                PS_END_OPEN:
                    if (is_letter(c)) begin
                        st = PS_TAG_NAME;
                        queue_word(EV_END, c, 1'b1, 1'b0);
                    end
                PS_MARKUP: begin
                    p = int'(kw_pos);
                    if (p >= DOCTYPE_LEN)
                        p = 0;
                    if (c == DOCTYPE_KW[8*(DOCTYPE_LEN-1-p) +: 8]) begin
                        p++;
                        if (p >= DOCTYPE_LEN) begin
                            p  = 0;
                            st = PS_DOCTYPE;
                        end
                    end else
                        p = (c == CH_D) ? 1 : 0;
                    kw_pos = p[2:0];
                end
                PS_DOCTYPE:
                    if (is_ws(c))
                        st = PS_BEFORE_DNAME;
                PS_BEFORE_DNAME: begin
                    st = PS_DNAME;
                    queue_word(EV_DOCTYPE, c, 1'b1, 1'b0);
                end
                default:
                    if (c == CH_GT) begin
                        st = PS_DATA;
                        queue_word(EV_DONE, 8'h00, 1'b0, 1'b0);
                    end else
                        queue_word(EV_DCHAR, c, 1'b1, 1'b0);
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("%0t MISMATCH: %s", $realtime, msg);
        endtask

        task check(res_t got);
            res_t want;
            if (words_q.size() == 0) begin
                report($sformatf("word with nothing owed: ev %0d char %02h has %0d sc %0d",
                                 got.event_res, got.char_value, got.has_char,
                                 got.slash_end));
                return;
            end
            want = words_q.pop_front();
            if (got.event_res !== want.event_res || got.char_value !== want.char_value ||
                got.has_char !== want.has_char || got.slash_end !== want.slash_end)
                report($sformatf({"got ev %0d char %02h has %0d sc %0d, ",
                                  "want ev %0d char %02h has %0d sc %0d"},
                                 got.event_res, got.char_value, got.has_char, got.slash_end,
                                 want.event_res, want.char_value, want.has_char,
                                 want.slash_end));
            else begin
                matched++;
                ev_count[got.event_res]++;
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       send_valid = 1'b0;
    logic [7:0] send_data = 8'h00;
    logic       take_ready = 1'b0;
    bit         calm = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    logic [7:0] frag_q[$];

    token_scoreboard sb = new();

    htt_byte_if  byte_ch ();
    htt_event_if event_ch ();

    assign byte_ch.valid   = send_valid;
    assign byte_ch.byte_in = send_data;
    assign event_ch.ready  = take_ready;

    html_tag_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (event_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_FF;
            default: return CH_SP;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    // anything that cannot end a tag or attribute name
    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 6)
            return pick_letter();
        c = 8'($urandom_range(0, 255));
        if (is_ws(c) || c == CH_GT || c == CH_SLASH || c == CH_EQ || c == CH_SQ || c == CH_DQ)
            c = "n";
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task add_str(string s);
        for (int i = 0; i < s.len(); i++)
            frag_q.push_back(s[i]);
    endtask

    task pause_sender(int n);
        @(negedge clk);
        send_valid <= 1'b0;
        send_data  <= 8'($urandom_range(0, 255));
        repeat (n - 1) @(negedge clk);
    endtask

    task send_queued();
        logic [7:0] b;
        int         gap;
        while (frag_q.size() > 0) begin
            b = frag_q.pop_front();
            @(negedge clk);
            send_valid <= 1'b1;
            send_data  <= b;
            @(posedge clk);
            while (!byte_ch.ready) @(posedge clk);
            sb.note_byte(b);
            gap = pick_gap();
            if (gap > 0)
                pause_sender(gap);
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            take_ready <= 1'b0;
            stall_left--;
        end else begin
            take_ready <= 1'b1;
            if (!calm) begin
                case ($urandom_range(0, 99)) inside
                    [0:64]:  stall_left = 0;
                    [65:92]: stall_left = $urandom_range(1, 3);
                    default: stall_left = $urandom_range(6, 40);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && event_ch.valid && event_ch.ready) begin
            got.event_res  = event_ch.event_res;
            got.char_value = event_ch.char_value;
            got.has_char   = event_ch.has_char;
            got.slash_end  = event_ch.slash_end;
            sb.check(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d events still owed",
                         quiet_cycles, sb.pending());
                $display("** html_tag_tokenizer: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int         kind;
        int         r;
        bit         drained_mid;
        logic [7:0] ch;
        logic [7:0] q;

        drained_mid = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: byte extremes, zero inside a tag, slash then '=' (empty attribute
        // name), top-bit value, self-closing end, doctype whose name starts with a space
        frag_q = {CH_NUL, 8'hFF, CH_SP, CH_LT, "b", CH_NUL, CH_SLASH, CH_EQ, CH_SQ,
                  8'h80, CH_SQ, CH_SLASH, CH_GT};
        add_str("<!DOCTYPE");
        frag_q.push_back(CH_TAB);
        frag_q.push_back(CH_SP);
        frag_q.push_back(CH_GT);
        send_queued();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge clk);

        while (sb.seen < ITEM_TARGET) begin
            if ($urandom_range(0, 29) == 0)
                calm = !calm;
            if (!drained_mid && sb.seen >= ITEM_TARGET / 2) begin
                drained_mid = 1'b1;
                pause_sender(1);
                while (sb.pending() != 0) @(posedge clk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 24) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 19);
                    if (r < 13)
                        ch = 8'($urandom_range(8'h21, 8'h7E));
                    else if (r < 17)
                        ch = pick_ws();
                    else
                        ch = 8'($urandom_range(0, 255));
                    if (ch == CH_LT)
                        ch = "t";
                    frag_q.push_back(ch);
                end
            end else if (kind < 62) begin
                frag_q.push_back(CH_LT);
                frag_q.push_back(pick_letter());
                repeat ($urandom_range(0, 4)) frag_q.push_back(pick_name_char());
                repeat ($urandom_range(0, 3)) begin
                    frag_q.push_back(pick_ws());
                    if ($urandom_range(0, 3) == 0)
                        frag_q.push_back(pick_ws());
                    r = $urandom_range(0, 3);
                    if ($urandom_range(0, 9) == 0) begin
                        frag_q.push_back(CH_EQ);
                        r = 1;
                    end else begin
                        repeat ($urandom_range(1, 4)) frag_q.push_back(pick_name_char());
                        if (r != 0)
                            frag_q.push_back(CH_EQ);
                    end
                    if (r != 0) begin
                        q = (r == 1) ? CH_SQ : CH_DQ;
                        frag_q.push_back(q);
                        repeat ($urandom_range(0, 5)) begin
                            ch = 8'($urandom_range(0, 255));
                            if (ch == q)
                                ch = "v";
                            frag_q.push_back(ch);
                        end
                        frag_q.push_back(q);
                    end
                end
                r = $urandom_range(0, 9);
                if (r >= 6)
                    frag_q.push_back(CH_SLASH);
                if (r == 9)
                    frag_q.push_back(pick_name_char());
                frag_q.push_back(CH_GT);
            end else if (kind < 76) begin
                add_str("</");
                frag_q.push_back(pick_letter());
                repeat ($urandom_range(0, 4)) frag_q.push_back(pick_name_char());
                frag_q.push_back(CH_GT);
            end else if (kind < 86) begin
                add_str("<!");
                case ($urandom_range(0, 3))
                    1: frag_q.push_back(CH_D);
                    2: add_str("DOC");
                    3: frag_q.push_back(8'($urandom_range(0, 255)));
                    default: ;
                endcase
                add_str("DOCTYPE");
                repeat ($urandom_range(1, 2)) frag_q.push_back(pick_ws());
                repeat ($urandom_range(1, 5)) begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CH_GT)
                        ch = "h";
                    frag_q.push_back(ch);
                end
                frag_q.push_back(CH_GT);
            end else if (kind < 92)
                frag_q.push_back(CH_NUL);
            else
                repeat ($urandom_range(1, 4)) frag_q.push_back(8'($urandom_range(0, 255)));
            send_queued();
        end

        pause_sender(1);
        calm = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d events never arrived", sb.pending()));

        $display("covered %0d bytes: tags, attributes, doctypes, eof, noise; %0d events matched",
                 sb.seen, sb.matched);
        $display({"char %0d eof %0d start %0d end %0d name %0d abegin %0d ",
                  "aname %0d aval %0d doctype %0d dchar %0d done %0d"},
                 sb.ev_count[EV_CHAR], sb.ev_count[EV_EOF], sb.ev_count[EV_START],
                 sb.ev_count[EV_END], sb.ev_count[EV_NAME], sb.ev_count[EV_ABEGIN],
                 sb.ev_count[EV_ANAME], sb.ev_count[EV_AVAL], sb.ev_count[EV_DOCTYPE],
                 sb.ev_count[EV_DCHAR], sb.ev_count[EV_DONE]);
        if (sb.errors == 0)
            $display("** html_tag_tokenizer: PASSED **");
        else
            $display("** html_tag_tokenizer: FAILED **");
        $finish;
    end

endmodule
